/* hdl/mexp_pkg.sv */
// shared types, constants and helper functions for the expression tokenizer
package mexp_pkg;

   localparam int POS_W = 16;
   localparam logic [POS_W-1:0] MAX_LEN = 16'hFFFF;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DIG0 = 8'h30;
   localparam logic [7:0] CH_DIG9 = 8'h39;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_UP_A = 8'h41;
   localparam logic [7:0] CH_UP_Z = 8'h5A;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_LO_A = 8'h61;
   localparam logic [7:0] CH_LO_U = 8'h75;
   localparam logic [7:0] CH_LO_V = 8'h76;
   localparam logic [7:0] CH_LO_X = 8'h78;
   localparam logic [7:0] CH_LO_Y = 8'h79;
   localparam logic [7:0] CH_LO_Z = 8'h7A;

   localparam int NUM_FUNCS = 5;
   localparam logic [23:0] FUNC_WORDS [NUM_FUNCS] = '{
      {8'h6E, 8'h69, 8'h73},   // sin
      {8'h73, 8'h6F, 8'h63},   // cos
      {8'h6E, 8'h61, 8'h74},   // tan
      {8'h70, 8'h78, 8'h65},   // exp
      {8'h67, 8'h6F, 8'h6C}    // log
   };

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_NUM  = 2'd1,
      MODE_WORD = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      TOK_NUMBER    = 4'd0,
      TOK_OPERATOR  = 4'd1,
      TOK_LPAREN    = 4'd2,
      TOK_RPAREN    = 4'd3,
      TOK_VARIABLE  = 4'd4,
      TOK_AXIS      = 4'd5,
      TOK_PARAMETER = 4'd6,
      TOK_FUNCTION  = 4'd7,
      TOK_UNKNOWN   = 4'd8,
      TOK_END       = 4'd9
   } tok_kind_type;

   typedef struct packed {
      logic [3:0]       token_type;
      logic [POS_W-1:0] start_res;
      logic [POS_W-1:0] length;
      logic [7:0]       symbol;
      logic [2:0]       function_id;
      logic             run_last;
      logic             string_end;
   } token_type;

   // up to two tokens caused by one input byte
   typedef struct packed {
      logic      v0;
      token_type t0;
      logic      v1;
      token_type t1;
   } entry_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_DIG0) && (c <= CH_DIG9);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
   endfunction

   function automatic token_type close_run(input mode_type mode, input logic [2:0] cnt,
                                           input logic [23:0] letters,
                                           input logic [POS_W-1:0] start,
                                           input logic [POS_W-1:0] end_pos);
      token_type t;
      logic [7:0] sym;
      sym = letters[7:0];
      t.token_type = TOK_UNKNOWN;
      t.start_res = start;
      t.length = end_pos - start;
      t.symbol = sym;
      t.function_id = 3'd0;
      t.run_last = 1'b0;
      t.string_end = 1'b0;
      if (mode == MODE_NUM) begin
         t.token_type = TOK_NUMBER;
      end else if (cnt == 3'd1) begin
         if (sym == CH_LO_U || sym == CH_LO_V) begin
            t.token_type = TOK_VARIABLE;
         end else if (sym == CH_LO_X || sym == CH_LO_Y || sym == CH_LO_Z) begin
            t.token_type = TOK_AXIS;
         end else begin
            t.token_type = TOK_PARAMETER;
         end
      end else if (cnt == 3'd3) begin
         for (int i = 0; i < NUM_FUNCS; i++) begin
            if (letters == FUNC_WORDS[i]) begin
               t.token_type = TOK_FUNCTION;
               t.function_id = 3'(i);
            end
         end
      end
      return t;
   endfunction

   function automatic token_type make_token(input tok_kind_type kind,
                                            input logic [POS_W-1:0] start,
                                            input logic [POS_W-1:0] len,
                                            input logic [7:0] sym);
      token_type t;
      t.token_type = kind;
      t.start_res = start;
      t.length = len;
      t.symbol = sym;
      t.function_id = 3'd0;
      t.run_last = 1'b0;
      t.string_end = 1'b0;
      return t;
   endfunction

endpackage

/* hdl/mexp_if.sv */
// handshake channels for input bytes and result tokens
interface mexp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;
   modport source (output valid, output ch, output last, input ready);
   modport sink (input valid, input ch, input last, output ready);
endinterface

interface mexp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [3:0]                token_type;
   logic [mexp_pkg::POS_W-1:0] start_res;
   logic [mexp_pkg::POS_W-1:0] length;
   logic [7:0]                symbol;
   logic [2:0]                function_id;
   logic                      run_last;
   logic                      string_end;
   modport source (output valid, output token_type, output start_res, output length,
                   output symbol, output function_id, output run_last, output string_end,
                   input ready);
   modport sink (input valid, input token_type, input start_res, input length,
                 input symbol, input function_id, input run_last, input string_end,
                 output ready);
endinterface

/* hdl/mexp_front.sv */
// front end: scans bytes, keeps the open token and classifies closed tokens
module mexp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [7:0]          in_ch,
   input  logic                in_last,
   input  logic                queue_ready,
   output logic                push,
   output mexp_pkg::entry_type push_entry
);

   mexp_pkg::mode_type              mode_ff, mode_in;
   logic [mexp_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [mexp_pkg::POS_W-1:0]      start_ff, start_in;
   logic [2:0]                      cnt_ff, cnt_in;
   logic [23:0]                     letters_ff, letters_in;

   logic                            accept;
   logic                            dig, dot, let_c, start_run, ext;
   logic [mexp_pkg::POS_W-1:0]      after;
   logic [2:0]                      grown_cnt;
   logic [23:0]                     grown_letters;
   mexp_pkg::mode_type              fresh_mode;
   mexp_pkg::tok_kind_type          single_kind;
   logic                            a_v, b_v;
   mexp_pkg::token_type             a_tok, b_tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= mexp_pkg::MODE_IDLE;
         pos_ff <= '0;
         start_ff <= '0;
         cnt_ff <= '0;
         letters_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         start_ff <= start_in;
         cnt_ff <= cnt_in;
         letters_ff <= letters_in;
      end
   end

   always_comb begin
      accept = in_valid && queue_ready;
      dig = mexp_pkg::is_digit(in_ch);
      dot = (in_ch == mexp_pkg::CH_DOT);
      let_c = mexp_pkg::is_letter(in_ch);
      start_run = dig || dot || let_c;
      fresh_mode = let_c ? mexp_pkg::MODE_WORD : mexp_pkg::MODE_NUM;
      ext = ((mode_ff == mexp_pkg::MODE_NUM) && (dig || dot)) ||
            ((mode_ff == mexp_pkg::MODE_WORD) && let_c);
      after = (pos_ff == mexp_pkg::MAX_LEN) ? pos_ff : pos_ff + 1'b1;

      grown_letters = letters_ff;
      if (cnt_ff < 3'd3) begin
         grown_letters = letters_ff | ({16'b0, in_ch} << {cnt_ff[1:0], 3'b000});
      end
      grown_cnt = (cnt_ff < 3'd4) ? cnt_ff + 1'b1 : cnt_ff;

      case (in_ch)
         mexp_pkg::CH_PLUS, mexp_pkg::CH_MINUS, mexp_pkg::CH_STAR,
         mexp_pkg::CH_SLASH, mexp_pkg::CH_CARET, mexp_pkg::CH_EQUAL:
            single_kind = mexp_pkg::TOK_OPERATOR;
         mexp_pkg::CH_LPAREN: single_kind = mexp_pkg::TOK_LPAREN;
         mexp_pkg::CH_RPAREN: single_kind = mexp_pkg::TOK_RPAREN;
         default: single_kind = mexp_pkg::TOK_UNKNOWN;
      endcase

      a_v = 1'b0;
      a_tok = mexp_pkg::close_run(mode_ff, cnt_ff, letters_ff, start_ff, pos_ff);
      b_v = 1'b0;
      b_tok = mexp_pkg::make_token(single_kind, pos_ff, 16'd1, in_ch);
      if (ext) begin
         b_v = in_last;
         b_tok = mexp_pkg::close_run(mode_ff, grown_cnt, grown_letters, start_ff, after);
      end else begin
         a_v = (mode_ff != mexp_pkg::MODE_IDLE);
         if (in_ch == mexp_pkg::CH_SPACE) begin
            b_v = in_last;
            b_tok = mexp_pkg::make_token(mexp_pkg::TOK_END, after, '0, 8'd0);
         end else if (in_ch == mexp_pkg::CH_NUL) begin
            b_v = 1'b1;
            b_tok = mexp_pkg::make_token(mexp_pkg::TOK_END, pos_ff, '0, 8'd0);
         end else if (start_run) begin
            b_v = in_last;
            b_tok = mexp_pkg::close_run(fresh_mode, 3'd1, {16'b0, in_ch}, pos_ff, after);
         end else begin
            b_v = 1'b1;
         end
      end

      // flag the last token of this byte
      if (b_v) begin
         b_tok.run_last = 1'b1;
         b_tok.string_end = in_last;
      end else begin
         a_tok.run_last = 1'b1;
         a_tok.string_end = in_last;
      end

      push = accept && (a_v || b_v);
      push_entry.v0 = a_v;
      push_entry.t0 = a_tok;
      push_entry.v1 = b_v;
      push_entry.t1 = b_tok;

      mode_in = mode_ff;
      pos_in = pos_ff;
      start_in = start_ff;
      cnt_in = cnt_ff;
      letters_in = letters_ff;
      if (accept) begin
         if (in_last) begin
            mode_in = mexp_pkg::MODE_IDLE;
            pos_in = '0;
            start_in = '0;
            cnt_in = '0;
            letters_in = '0;
         end else begin
            if (pos_ff != mexp_pkg::MAX_LEN) begin
               pos_in = pos_ff + 1'b1;
            end
            if (ext) begin
               if (mode_ff == mexp_pkg::MODE_WORD) begin
                  cnt_in = grown_cnt;
                  letters_in = grown_letters;
               end
            end else if (start_run) begin
               mode_in = fresh_mode;
               start_in = pos_ff;
               cnt_in = 3'd1;
               letters_in = {16'b0, in_ch};
            end else begin
               mode_in = mexp_pkg::MODE_IDLE;
            end
         end
      end
   end

endmodule

/* hdl/mexp_queue.sv */
// short show-ahead queue of token pairs between front and back
module mexp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mexp_pkg::entry_type push_entry,
   output logic                can_push,
   input  logic                pop,
   output logic                head_valid,
   output mexp_pkg::entry_type head_entry
);

   mexp_pkg::entry_type               mem_ff [mexp_pkg::QUEUE_DEPTH];
   logic [mexp_pkg::QUEUE_AW-1:0]     wr_ff, wr_in;
   logic [mexp_pkg::QUEUE_AW-1:0]     rd_ff, rd_in;
   logic [mexp_pkg::QUEUE_AW:0]       count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   always_comb begin
      can_push = (count_ff != (mexp_pkg::QUEUE_AW+1)'(mexp_pkg::QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_entry = mem_ff[rd_ff];
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

endmodule

/* hdl/mexp_back.sv */
// back end: splits token pairs into single words on a registered output
module mexp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  mexp_pkg::entry_type head_entry,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output mexp_pkg::token_type out_tok
);

   logic                phase_ff, phase_in;
   logic                valid_ff, valid_in;
   mexp_pkg::token_type tok_ff, tok_in;
   logic                fire, sel1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   always_comb begin
      fire = head_valid && (!valid_ff || out_ready);
      sel1 = phase_ff || !head_entry.v0;
      tok_in = tok_ff;
      if (fire) begin
         tok_in = sel1 ? head_entry.t1 : head_entry.t0;
      end
      pop = fire && (sel1 || !head_entry.v1);
      phase_in = phase_ff;
      if (fire) begin
         phase_in = !pop;
      end
      valid_in = fire || (valid_ff && !out_ready);
      out_valid = valid_ff;
      out_tok = tok_ff;
   end

endmodule

/* hdl/math_expression_tokenizer_unit.sv */
// Streaming lexer for arithmetic expressions: takes one byte word per cycle on req_bus
// while the queue has room and returns one token word per cycle on rsp_bus while the
// sink is ready. The front end classifies each byte combinationally and hands the zero,
// one or two tokens it closes to a four-entry queue; the back end sends them one at a
// time through an output register. A byte that closes two tokens gives two output words;
// the sustained rate is one output word per clock, set by the single-word output register.
module math_expression_tokenizer_unit (
   input  logic               clock,
   input  logic               reset,
   mexp_req_if.sink           req_bus,
   mexp_rsp_if.source         rsp_bus
);

   logic                queue_ready;
   logic                push;
   mexp_pkg::entry_type push_entry;
   logic                pop;
   logic                head_valid;
   mexp_pkg::entry_type head_entry;
   mexp_pkg::token_type out_tok;

   assign req_bus.ready = queue_ready;

   mexp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_bus.valid),
      .in_ch       (req_bus.ch),
      .in_last     (req_bus.last),
      .queue_ready (queue_ready),
      .push        (push),
      .push_entry  (push_entry)
   );

   mexp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .can_push   (queue_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   mexp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_tok    (out_tok)
   );

   assign rsp_bus.token_type = out_tok.token_type;
   assign rsp_bus.start_res = out_tok.start_res;
   assign rsp_bus.length = out_tok.length;
   assign rsp_bus.symbol = out_tok.symbol;
   assign rsp_bus.function_id = out_tok.function_id;
   assign rsp_bus.run_last = out_tok.run_last;
   assign rsp_bus.string_end = out_tok.string_end;

endmodule
